// ===== rtl/core/brlt_pkg.sv =====
package brlt_pkg;

   localparam int MAX_LOCKS_DEF   = 16;
   localparam int OWNER_BITS_DEF  = 8;
   localparam int OFFSET_BITS_DEF = 63;
   localparam int PID_BITS        = 22;

   typedef logic [1:0] code_type;

   // operations
   localparam code_type OP_TEST   = 2'd0;
   localparam code_type OP_SET    = 2'd1;
   localparam code_type OP_REMOVE = 2'd2;
   localparam code_type OP_RSVD   = 2'd3;

   // lock types
   localparam code_type LT_READ   = 2'd0;
   localparam code_type LT_WRITE  = 2'd1;
   localparam code_type LT_UNLOCK = 2'd2;
   localparam code_type LT_RSVD   = 2'd3;

   // response status
   localparam code_type ST_OK      = 2'd0;
   localparam code_type ST_BLOCK   = 2'd1;
   localparam code_type ST_FULL    = 2'd2;
   localparam code_type ST_INVALID = 2'd3;

   // conflict type when nothing conflicts
   localparam code_type CT_NONE = 2'd2;

   typedef struct packed {
      logic busy;
      logic shift;
   } brlt_stat_type;

endpackage

// ===== rtl/core/brlt_req_if.sv =====
interface brlt_req_if import brlt_pkg::*; #(
   parameter int OWNER_BITS  = OWNER_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             operation;
   logic [OWNER_BITS-1:0]  owner;
   logic [1:0]             lock_type;
   logic [OFFSET_BITS-1:0] range_start;
   logic [OFFSET_BITS-1:0] range_end;
   logic [PID_BITS-1:0]    pid;

   modport source (output valid, operation, owner, lock_type, range_start, range_end, pid,
                   input ready);
   modport sink (input valid, operation, owner, lock_type, range_start, range_end, pid,
                 output ready);
endinterface

// ===== rtl/core/brlt_rsp_if.sv =====
interface brlt_rsp_if import brlt_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic                   unlock_event;
   logic [1:0]             conflict_type;
   logic [OFFSET_BITS-1:0] conflict_start;
   logic [OFFSET_BITS-1:0] conflict_end;
   logic [PID_BITS-1:0]    conflict_pid;

   modport source (output valid, status, unlock_event, conflict_type, conflict_start,
                   conflict_end, conflict_pid, input ready);
   modport sink (input valid, status, unlock_event, conflict_type, conflict_start,
                 conflict_end, conflict_pid, output ready);
endinterface

// ===== rtl/core/brlt_cell.sv =====
module brlt_cell import brlt_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data
);
   logic              valid_ff;
   logic [DATA_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== rtl/core/brlt_ctrl.sv =====
module brlt_ctrl import brlt_pkg::*; #(
   parameter int MAX_LOCKS   = MAX_LOCKS_DEF,
   parameter int OWNER_BITS  = OWNER_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int DATA_W      = OWNER_BITS + 1 + 2 * OFFSET_BITS + PID_BITS
) (
   input  logic              clock,
   input  logic              reset,
   brlt_req_if.sink          req_chan,
   brlt_rsp_if.source        rsp_chan,
   input  logic              head_valid,
   input  logic [DATA_W-1:0] head_data,
   output logic              tail_valid,
   output logic [DATA_W-1:0] tail_data,
   output brlt_stat_type     stat
);
   localparam int IDX_W = $clog2(MAX_LOCKS);
   localparam int CNT_W = $clog2(MAX_LOCKS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CONF   = 3'd1;
   localparam logic [2:0] S_MERGE  = 3'd2;
   localparam logic [2:0] S_PLAN   = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_REMOVE = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam logic [OFFSET_BITS-1:0] ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

   logic [2:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   code_type               op_ff, op_in, type_ff, type_in, status_ff, status_in;
   logic [OWNER_BITS-1:0]  own_ff, own_in;
   logic [OFFSET_BITS-1:0] rs_ff, rs_in, re_ff, re_in, cs_ff, cs_in, ce_ff, ce_in;
   logic [PID_BITS-1:0]    pid_ff, pid_in;
   logic                   changed_ff, changed_in;
   logic                   hit_ff, hit_in, hit_wr_ff, hit_wr_in;
   logic [OFFSET_BITS-1:0] hit_start_ff, hit_start_in, hit_end_ff, hit_end_in;
   logic [PID_BITS-1:0]    hit_pid_ff, hit_pid_in;
   logic [CNT_W-1:0]       free_ff, free_in;
   logic                   split_ff, split_in, sp_wr_ff, sp_wr_in;
   logic [OFFSET_BITS-1:0] sp_end_ff, sp_end_in;
   logic [PID_BITS-1:0]    sp_pid_ff, sp_pid_in;
   logic                   ins_ff, ins_in;
   logic                   ev_ff, ev_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   code_type               rsp_status_ff, rsp_status_in, rsp_ctype_ff, rsp_ctype_in;
   logic                   rsp_ev_ff, rsp_ev_in;
   logic [OFFSET_BITS-1:0] rsp_start_ff, rsp_start_in, rsp_end_ff, rsp_end_in;
   logic [PID_BITS-1:0]    rsp_pid_ff, rsp_pid_in;

   logic [OWNER_BITS-1:0]  h_owner;
   logic                   h_wr;
   logic [OFFSET_BITS-1:0] h_start, h_end;
   logic [PID_BITS-1:0]    h_pid;
   logic                   own_match, conf_ovl, cur_ovl, touch, same_kind, is_unlock;
   logic                   absorb, other, covers, inner, post_valid, conflict;
   logic                   last, shifting, bad, hit_now, split_now;
   logic [CNT_W-1:0]       free_now, need;
   logic [OFFSET_BITS-1:0] t_start, t_end;

   assign {h_owner, h_wr, h_start, h_end, h_pid} = head_data;

   assign is_unlock = (type_ff == LT_UNLOCK);
   assign own_match = head_valid && (h_owner == own_ff);
   assign conf_ovl  = (h_end >= rs_ff) && (re_ff >= h_start);
   assign cur_ovl   = (h_end >= cs_ff) && (ce_ff >= h_start);
   assign touch     = ({1'b0, ce_ff} + {1'b0, ONE} == {1'b0, h_start}) ||
                      ({1'b0, h_end} + {1'b0, ONE} == {1'b0, cs_ff});
   assign same_kind = !is_unlock && (h_wr == type_ff[0]);
   assign absorb    = own_match && same_kind && (cur_ovl || touch);
   assign other     = own_match && !same_kind && cur_ovl;
   assign covers    = (cs_ff <= h_start) && (ce_ff >= h_end);
   assign inner     = (cs_ff > h_start) && (ce_ff < h_end);
   assign post_valid = head_valid && !absorb && !(other && covers);
   assign conflict  = head_valid && (h_owner != own_ff) && conf_ovl &&
                      (h_wr || type_ff == LT_WRITE);

   assign last     = (idx_ff == IDX_W'(MAX_LOCKS - 1));
   assign shifting = (state_ff == S_CONF) || (state_ff == S_MERGE) || (state_ff == S_PLAN) ||
                     (state_ff == S_COMMIT) || (state_ff == S_REMOVE);

   assign bad = (req_chan.operation == OP_RSVD) ||
                (req_chan.operation == OP_TEST && req_chan.lock_type >= LT_UNLOCK) ||
                (req_chan.operation == OP_SET && req_chan.lock_type == LT_RSVD) ||
                (req_chan.operation != OP_REMOVE && req_chan.range_start > req_chan.range_end);

   assign hit_now   = hit_ff || conflict;
   assign split_now = split_ff || (other && inner);
   assign free_now  = free_ff + CNT_W'(!post_valid);
   assign need      = CNT_W'(split_now) + CNT_W'(!is_unlock);

   // trimmed bounds of an owner lock of the other kind
   always_comb begin
      t_start = h_start;
      t_end   = h_end;
      if (other && (inner || h_start < cs_ff)) begin
         t_end = cs_ff - ONE;
      end else if (other) begin
         t_start = ce_ff + ONE;
      end
   end

   // head entry returns at the tail; commit may alter or drop it, remove drops owner entries
   always_comb begin
      tail_valid = head_valid;
      tail_data  = head_data;
      case (state_ff)
         S_COMMIT: begin
            tail_valid = post_valid;
            tail_data  = {h_owner, h_wr, t_start, t_end, h_pid};
            if (!post_valid && split_ff) begin
               tail_valid = 1'b1;
               tail_data  = {own_ff, sp_wr_ff, ce_ff + ONE, sp_end_ff, sp_pid_ff};
            end else if (!post_valid && ins_ff) begin
               tail_valid = 1'b1;
               tail_data  = {own_ff, type_ff[0], cs_ff, ce_ff, pid_ff};
            end
         end
         S_REMOVE: tail_valid = head_valid && !own_match;
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = shifting ? (last ? '0 : idx_ff + 1'b1) : '0;
      op_in        = op_ff;
      type_in      = type_ff;
      own_in       = own_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      pid_in       = pid_ff;
      cs_in        = cs_ff;
      ce_in        = ce_ff;
      status_in    = status_ff;
      changed_in   = changed_ff;
      hit_in       = hit_ff;
      hit_wr_in    = hit_wr_ff;
      hit_start_in = hit_start_ff;
      hit_end_in   = hit_end_ff;
      hit_pid_in   = hit_pid_ff;
      free_in      = free_ff;
      split_in     = split_ff;
      sp_wr_in     = sp_wr_ff;
      sp_end_in    = sp_end_ff;
      sp_pid_in    = sp_pid_ff;
      ins_in       = ins_ff;
      ev_in        = ev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_ctype_in = rsp_ctype_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_pid_in   = rsp_pid_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.operation;
               type_in   = req_chan.lock_type;
               own_in    = req_chan.owner;
               rs_in     = req_chan.range_start;
               re_in     = req_chan.range_end;
               cs_in     = req_chan.range_start;
               ce_in     = req_chan.range_end;
               pid_in    = req_chan.pid;
               status_in = bad ? ST_INVALID : ST_OK;
               hit_in    = 1'b0;
               ev_in     = 1'b0;
               free_in   = '0;
               split_in  = 1'b0;
               if (bad) begin
                  state_in = S_DONE;
               end else if (req_chan.operation == OP_REMOVE) begin
                  state_in = S_REMOVE;
               end else if (req_chan.operation == OP_SET &&
                            req_chan.lock_type == LT_UNLOCK) begin
                  state_in = S_PLAN;
               end else begin
                  state_in = S_CONF;
               end
            end
         end
         S_CONF: begin
            if (conflict && !hit_ff) begin
               hit_in       = 1'b1;
               hit_wr_in    = h_wr;
               hit_start_in = h_start;
               hit_end_in   = h_end;
               hit_pid_in   = h_pid;
            end
            if (last) begin
               changed_in = 1'b0;
               if (op_ff == OP_TEST) begin
                  state_in = S_DONE;
               end else if (hit_now) begin
                  status_in = ST_BLOCK;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_MERGE;
               end
            end
         end
         S_MERGE: begin
            if (absorb) begin
               if (h_start < cs_ff) cs_in = h_start;
               if (h_end > ce_ff) ce_in = h_end;
               if (h_start < cs_ff || h_end > ce_ff) changed_in = 1'b1;
            end
            // repeat the pass until the merged range stops growing
            if (last) begin
               changed_in = 1'b0;
               if (!(changed_in || changed_ff || (absorb &&
                     (h_start < cs_ff || h_end > ce_ff)))) begin
                  state_in = S_PLAN;
               end
            end
         end
         S_PLAN: begin
            free_in  = free_now;
            split_in = split_now;
            if (other) ev_in = 1'b1;
            if (other && inner) begin
               sp_wr_in  = h_wr;
               sp_end_in = h_end;
               sp_pid_in = h_pid;
            end
            if (last) begin
               if (free_now < need) begin
                  status_in = ST_FULL;
                  ev_in     = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  ins_in   = !is_unlock;
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            if (!post_valid && split_ff) begin
               split_in = 1'b0;
            end else if (!post_valid && ins_ff) begin
               ins_in = 1'b0;
            end
            if (last) state_in = S_DONE;
         end
         S_REMOVE: begin
            if (last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_ev_in     = ev_ff;
               rsp_ctype_in  = hit_ff ? (hit_wr_ff ? LT_WRITE : LT_READ) : CT_NONE;
               rsp_start_in  = hit_ff ? hit_start_ff : '0;
               rsp_end_in    = hit_ff ? hit_end_ff : '0;
               rsp_pid_in    = hit_ff ? hit_pid_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      type_ff       <= type_in;
      own_ff        <= own_in;
      rs_ff         <= rs_in;
      re_ff         <= re_in;
      pid_ff        <= pid_in;
      cs_ff         <= cs_in;
      ce_ff         <= ce_in;
      status_ff     <= status_in;
      changed_ff    <= changed_in;
      hit_ff        <= hit_in;
      hit_wr_ff     <= hit_wr_in;
      hit_start_ff  <= hit_start_in;
      hit_end_ff    <= hit_end_in;
      hit_pid_ff    <= hit_pid_in;
      free_ff       <= free_in;
      split_ff      <= split_in;
      sp_wr_ff      <= sp_wr_in;
      sp_end_ff     <= sp_end_in;
      sp_pid_ff     <= sp_pid_in;
      ins_ff        <= ins_in;
      ev_ff         <= ev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_ctype_ff  <= rsp_ctype_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_pid_ff    <= rsp_pid_in;
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.unlock_event   = rsp_ev_ff;
   assign rsp_chan.conflict_type  = rsp_ctype_ff;
   assign rsp_chan.conflict_start = rsp_start_ff;
   assign rsp_chan.conflict_end   = rsp_end_ff;
   assign rsp_chan.conflict_pid   = rsp_pid_ff;

   assign stat.busy  = (state_ff != S_IDLE);
   assign stat.shift = shifting;
endmodule

// ===== rtl/core/byte_range_lock_table_core.sv =====
// passes over the ring: an invalid request makes none; test, remove and blocked set make one
// set makes k+3 and unlock 2, where k >= 1 is the number of merge passes
// a set or unlock that finds the table full answers one pass earlier
// one request at a time; each pass rotates the cell ring once, one entry per cycle
// a new request is taken while the previous response still waits
// synchronous reset clears every entry valid bit, leaving the table empty
module byte_range_lock_table_core import brlt_pkg::*; #(
   parameter int MAX_LOCKS   = MAX_LOCKS_DEF,
   parameter int OWNER_BITS  = OWNER_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   brlt_req_if.sink   req_chan,
   brlt_rsp_if.source rsp_chan
);
   localparam int DATA_W = OWNER_BITS + 1 + 2 * OFFSET_BITS + PID_BITS;

   logic              cell_valid [MAX_LOCKS];
   logic [DATA_W-1:0] cell_data  [MAX_LOCKS];
   logic              tail_valid;
   logic [DATA_W-1:0] tail_data;
   brlt_stat_type     stat;

   brlt_ctrl #(
      .MAX_LOCKS   (MAX_LOCKS),
      .OWNER_BITS  (OWNER_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .DATA_W      (DATA_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .head_valid (cell_valid[0]),
      .head_data  (cell_data[0]),
      .tail_valid (tail_valid),
      .tail_data  (tail_data),
      .stat       (stat)
   );

   // cell 0 is the head seen by the controller, the last cell takes its output
   for (genvar i = 0; i < MAX_LOCKS; i++) begin : g_cell
      if (i == MAX_LOCKS - 1) begin : g_tail
         brlt_cell #(.DATA_W(DATA_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (stat.shift),
            .in_valid  (tail_valid),
            .in_data   (tail_data),
            .out_valid (cell_valid[i]),
            .out_data  (cell_data[i])
         );
      end else begin : g_mid
         brlt_cell #(.DATA_W(DATA_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (stat.shift),
            .in_valid  (cell_valid[i+1]),
            .in_data   (cell_data[i+1]),
            .out_valid (cell_valid[i]),
            .out_data  (cell_data[i])
         );
      end
   end

   a_shift_busy: assert property (@(posedge clock) disable iff (reset)
      stat.shift |-> stat.busy)
      else $error("ring rotates while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (stat.busy || rsp_chan.valid))
      else $error("request accepted but not worked on");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_FULL) |->
      (rsp_chan.conflict_type == CT_NONE && !rsp_chan.unlock_event))
      else $error("table full response carries stale fields");
endmodule
